### hdl/dsps_pkg.sv
// shared types, constants and coil tables of the dual stepper phase sequencer
`default_nettype none
package dsps_pkg;

    // default clamp for both motor speeds
    localparam int unsigned MAX_SPEED_DEF = 10;

    // field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned DELAY_W   = 8;
    localparam int unsigned ELAPSED_W = 26;
    localparam int unsigned TOUT_W    = 16;
    localparam int unsigned MODE_W    = 4;
    localparam int unsigned RATIO_W   = 4;
    localparam int unsigned SLOTS_W   = 8;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [9:0]           MS_PER_SEC  = 10'd1000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SPEED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLOT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_STEP_MODE   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_S   = 3'd1;
    localparam logic [2:0] REG_BASE_DELAY  = 3'd2;
    localparam logic [2:0] REG_SPEED_RATIO = 3'd3;
    localparam logic [2:0] REG_SLOTS_BURST = 3'd4;
    localparam logic [2:0] REG_LIMIT_EN    = 3'd5;
    localparam logic [2:0] REG_LIMIT_LEVEL = 3'd6;

    // register reset values and step mode constants
    localparam logic [MODE_W-1:0]  STEP_MODE_RST   = 4'd1;
    localparam logic [TOUT_W-1:0]  TIMEOUT_S_RST   = 16'd1;
    localparam logic [DELAY_W-1:0] BASE_DELAY_RST  = 8'd10;
    localparam logic [RATIO_W-1:0] SPEED_RATIO_RST = 4'd1;
    localparam logic [SLOTS_W-1:0] SLOTS_BURST_RST = 8'd8;
    localparam logic [MODE_W-1:0]  FULL_STEP_MODE  = 4'd4;
    localparam logic [MODE_W-1:0]  MODE_MAX        = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [SPEED_W-1:0] speed_a;
        logic signed [SPEED_W-1:0] speed_b;
        logic                      limit_left;
        logic                      limit_right;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0]  coils_a;
        logic [COIL_W-1:0]  coils_b;
        logic [DELAY_W-1:0] slot_delay_ms;
        logic               moving;
        logic               timed_out;
        logic               limit_hit;
    } t_out_item;

    // half-step coil table
    function automatic logic [COIL_W-1:0] half_coils(input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] c;
        unique case (p)
            3'd0:    c = 4'b0001;
            3'd1:    c = 4'b0011;
            3'd2:    c = 4'b0010;
            3'd3:    c = 4'b0110;
            3'd4:    c = 4'b0100;
            3'd5:    c = 4'b1100;
            3'd6:    c = 4'b1000;
            default: c = 4'b1001;
        endcase
        return c;
    endfunction

    // full-step coil table
    function automatic logic [COIL_W-1:0] full_coils(input logic [1:0] p);
        logic [COIL_W-1:0] c;
        unique case (p)
            2'd0:    c = 4'b1010;
            2'd1:    c = 4'b0110;
            2'd2:    c = 4'b0101;
            default: c = 4'b1001;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/dual_stepper_phase_sequencer_core.sv
// top level of the dual stepper phase sequencer: command handling, phase state, serial divider
//
// usage
// - input channel i_in_valid / o_in_stall / i_in_data carries one command beat:
//   a speed command, a step slot or a one millisecond tick
// - output channel o_out_valid / i_out_stall / o_out_data returns exactly one
//   result beat per input beat, in order
// - the user writes registers over the apb port only while no beat is in flight; unchecked
// flow
// - a step slot that moves a motor: the slot delay comes from a restoring
//   divider that retires one quotient bit per cycle; the beat passes from
//   idle through the divide state and the done state into the output register
// - every other beat goes from idle straight to the done state
// - the sequencer holds one item at a time and takes the next beat only
//   once the previous one has left the done state
// reset
// - synchronous, active low; registers return to their defaults, both motors
//   stop with coils off and phase zero, the output register empties
// stall
// - a result waits in the output register while i_out_stall is high; the next
//   beat is still accepted and worked on, and waits in its done state until
//   the output register frees
`default_nettype none
module dual_stepper_phase_sequencer_core #(
    parameter int unsigned MAX_SPEED = dsps_pkg::MAX_SPEED_DEF   // 1 to 15
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire dsps_pkg::t_in_item           i_in_data,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output dsps_pkg::t_out_item               o_out_data,
    // apb configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsps_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dsps_pkg::APB_DW-1:0]  pwdata,
    output logic [dsps_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    // magnitude of a clamped speed and its signed form
    localparam int unsigned MAG_W = $clog2(MAX_SPEED + 1);
    localparam int unsigned SPD_W = MAG_W + 1;
    localparam int unsigned CNT_W = $clog2(dsps_pkg::DELAY_W);

    localparam logic signed [dsps_pkg::SPEED_W-1:0] SPD_HI = dsps_pkg::SPEED_W'(MAX_SPEED);
    localparam logic signed [dsps_pkg::SPEED_W-1:0] SPD_LO = -SPD_HI;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [dsps_pkg::COIL_W-1:0]  coils;
        logic [dsps_pkg::PHASE_W-1:0] phase;
    } t_adv;

    // configuration registers
    logic [dsps_pkg::MODE_W-1:0]    r_step_mode,   n_step_mode;
    logic [dsps_pkg::TOUT_W-1:0]    r_timeout_s,   n_timeout_s;
    logic [dsps_pkg::ELAPSED_W-1:0] r_timeout_ms,  n_timeout_ms;
    logic [dsps_pkg::DELAY_W-1:0]   r_base_delay,  n_base_delay;
    logic [dsps_pkg::RATIO_W-1:0]   r_speed_ratio, n_speed_ratio;
    logic [dsps_pkg::SLOTS_W-1:0]   r_slots_burst, n_slots_burst;
    logic                           r_limit_en,    n_limit_en;
    logic                           r_limit_level, n_limit_level;

    // motor state
    logic signed [SPD_W-1:0]        r_speed_a,  n_speed_a;
    logic signed [SPD_W-1:0]        r_speed_b,  n_speed_b;
    logic [dsps_pkg::PHASE_W-1:0]   r_phase_a,  n_phase_a;
    logic [dsps_pkg::PHASE_W-1:0]   r_phase_b,  n_phase_b;
    logic [dsps_pkg::COIL_W-1:0]    r_coils_a,  n_coils_a;
    logic [dsps_pkg::COIL_W-1:0]    r_coils_b,  n_coils_b;
    logic [dsps_pkg::RATIO_W-1:0]   r_ratio_cd, n_ratio_cd;
    logic [dsps_pkg::SLOTS_W-1:0]   r_burst,    n_burst;
    logic [dsps_pkg::ELAPSED_W-1:0] r_elapsed,  n_elapsed;

    // sequencer, divider and output
    t_state                         r_state,    n_state;
    logic [dsps_pkg::DELAY_W-1:0]   r_div_q,    n_div_q;
    logic [MAG_W-1:0]               r_div_rem,  n_div_rem;
    logic [MAG_W-1:0]               r_div_d,    n_div_d;
    logic [CNT_W-1:0]               r_div_cnt,  n_div_cnt;
    dsps_pkg::t_out_item            r_pend,     n_pend;
    dsps_pkg::t_out_item            r_out,      n_out;
    logic                           r_out_valid, n_out_valid;

    logic w_in_acc;
    logic w_cfg_wr;

    // clamp a requested speed to the allowed range
    function automatic logic signed [SPD_W-1:0] clamp_speed(
        input logic signed [dsps_pkg::SPEED_W-1:0] s
    );
        logic signed [dsps_pkg::SPEED_W-1:0] c;
        if (s < SPD_LO) begin
            c = SPD_LO;
        end else if (s > SPD_HI) begin
            c = SPD_HI;
        end else begin
            c = s;
        end
        return c[SPD_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [SPD_W-1:0] s);
        logic signed [SPD_W-1:0] m;
        m = (s < 0) ? -s : s;
        return m[MAG_W-1:0];
    endfunction

    // coil pattern for the current phase, then the phase after one step
    function automatic t_adv advance(
        input logic [dsps_pkg::PHASE_W-1:0] p,
        input logic                         neg,
        input logic [dsps_pkg::MODE_W-1:0]  mode
    );
        t_adv                             a;
        logic [dsps_pkg::MODE_W-1:0]      sum;
        logic [dsps_pkg::MODE_W-1:0]      pw;
        pw  = {1'b0, p};
        sum = pw + mode;
        if (mode == dsps_pkg::FULL_STEP_MODE) begin
            a.coils = p[2] ? '0 : dsps_pkg::full_coils(p[1:0]);
            if (neg) begin
                a.phase = (p >= 3'd3) ? 3'd0 : p + 3'd1;
            end else if (p == 3'd0) begin
                a.phase = 3'd3;
            end else begin
                a.phase = (p >= 3'd5) ? 3'd0 : p - 3'd1;
            end
        end else begin
            a.coils = dsps_pkg::half_coils(p);
            if (neg) begin
                a.phase = (sum > 4'd7) ? 3'd0 : sum[dsps_pkg::PHASE_W-1:0];
            end else begin
                a.phase = (pw >= mode) ? 3'(pw - mode) : 3'd7;
            end
        end
        return a;
    endfunction

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_wr    = psel && penable && pwrite && pready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;

    // register writes
    always_comb begin
        n_step_mode   = r_step_mode;
        n_timeout_s   = r_timeout_s;
        n_timeout_ms  = r_timeout_ms;
        n_base_delay  = r_base_delay;
        n_speed_ratio = r_speed_ratio;
        n_slots_burst = r_slots_burst;
        n_limit_en    = r_limit_en;
        n_limit_level = r_limit_level;
        if (w_cfg_wr) begin
            unique case (paddr[4:2])
                dsps_pkg::REG_STEP_MODE: begin
                    // out-of-range modes are dropped
                    if (pwdata[3:0] != '0 && pwdata[3:0] <= dsps_pkg::MODE_MAX) begin
                        n_step_mode = pwdata[dsps_pkg::MODE_W-1:0];
                    end
                end
                dsps_pkg::REG_TIMEOUT_S: begin
                    n_timeout_s  = pwdata[dsps_pkg::TOUT_W-1:0];
                    // seconds to milliseconds once, at write time
                    n_timeout_ms = dsps_pkg::ELAPSED_W'(pwdata[dsps_pkg::TOUT_W-1:0]
                                                        * dsps_pkg::MS_PER_SEC);
                end
                dsps_pkg::REG_BASE_DELAY:  n_base_delay  = pwdata[dsps_pkg::DELAY_W-1:0];
                dsps_pkg::REG_SPEED_RATIO: n_speed_ratio = pwdata[dsps_pkg::RATIO_W-1:0];
                dsps_pkg::REG_SLOTS_BURST: n_slots_burst = pwdata[dsps_pkg::SLOTS_W-1:0];
                dsps_pkg::REG_LIMIT_EN:    n_limit_en    = pwdata[0];
                dsps_pkg::REG_LIMIT_LEVEL: n_limit_level = pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            dsps_pkg::REG_STEP_MODE:   prdata = dsps_pkg::APB_DW'(r_step_mode);
            dsps_pkg::REG_TIMEOUT_S:   prdata = dsps_pkg::APB_DW'(r_timeout_s);
            dsps_pkg::REG_BASE_DELAY:  prdata = dsps_pkg::APB_DW'(r_base_delay);
            dsps_pkg::REG_SPEED_RATIO: prdata = dsps_pkg::APB_DW'(r_speed_ratio);
            dsps_pkg::REG_SLOTS_BURST: prdata = dsps_pkg::APB_DW'(r_slots_burst);
            dsps_pkg::REG_LIMIT_EN:    prdata = dsps_pkg::APB_DW'(r_limit_en);
            dsps_pkg::REG_LIMIT_LEVEL: prdata = dsps_pkg::APB_DW'(r_limit_level);
            default:                   prdata = '0;
        endcase
    end

    // command decode and motor state update, all in the accept cycle
    always_comb begin
        logic signed [SPD_W-1:0]      v_sa;
        logic signed [SPD_W-1:0]      v_sb;
        logic [dsps_pkg::RATIO_W-1:0] v_ratio;
        logic [dsps_pkg::SLOTS_W:0]   v_slots;
        logic [dsps_pkg::SLOTS_W:0]   v_bnext;
        logic                         v_tout;
        logic                         v_lhit;
        logic                         v_step;
        logic                         v_lvl;
        logic [MAG_W-1:0]             v_ma;
        logic [MAG_W-1:0]             v_mb;
        t_adv                         v_adv_a;
        t_adv                         v_adv_b;

        n_speed_a  = r_speed_a;
        n_speed_b  = r_speed_b;
        n_phase_a  = r_phase_a;
        n_phase_b  = r_phase_b;
        n_coils_a  = r_coils_a;
        n_coils_b  = r_coils_b;
        n_ratio_cd = r_ratio_cd;
        n_burst    = r_burst;
        n_elapsed  = r_elapsed;

        v_ratio = (r_speed_ratio == '0) ? dsps_pkg::RATIO_W'(1) : r_speed_ratio;
        v_slots = (r_slots_burst == '0) ? (dsps_pkg::SLOTS_W+1)'(1) : {1'b0, r_slots_burst};
        v_sa    = r_speed_a;
        v_sb    = r_speed_b;
        v_tout  = 1'b0;
        v_lhit  = 1'b0;
        v_step  = 1'b0;
        v_lvl   = 1'b0;
        v_bnext = '0;
        v_ma    = '0;
        v_mb    = '0;
        v_adv_a = advance(r_phase_a, r_speed_a < 0, r_step_mode);
        v_adv_b = advance(r_phase_b, r_speed_b < 0, r_step_mode);

        if (w_in_acc) begin
            if (i_in_data.cmd == dsps_pkg::CMD_SPEED) begin
                v_sa = clamp_speed(i_in_data.speed_a);
                v_sb = clamp_speed(i_in_data.speed_b);
                if (v_sa == '0) begin
                    n_coils_a = '0;
                    n_phase_a = '0;
                end
                if (v_sb == '0) begin
                    n_coils_b = '0;
                    n_phase_b = '0;
                end
                if (v_sa != '0 || v_sb != '0) begin
                    n_elapsed = '0;
                end
                n_burst    = '0;
                n_ratio_cd = v_ratio;
            end else if (i_in_data.cmd == dsps_pkg::CMD_TICK) begin
                if (r_elapsed != dsps_pkg::ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else if (i_in_data.cmd == dsps_pkg::CMD_SLOT &&
                         (r_speed_a != '0 || r_speed_b != '0)) begin
                // checks at the first slot of a burst
                if (r_burst == '0) begin
                    if (r_timeout_s != '0 && r_elapsed >= r_timeout_ms) begin
                        v_sa      = '0;
                        v_sb      = '0;
                        n_phase_a = '0;
                        n_phase_b = '0;
                        n_coils_a = '0;
                        n_coils_b = '0;
                        v_tout    = 1'b1;
                    end
                    v_lvl = (v_sb < 0) ? i_in_data.limit_left : i_in_data.limit_right;
                    if (r_limit_en && v_sb != '0 && v_lvl == r_limit_level) begin
                        v_sb      = '0;
                        n_phase_b = '0;
                        n_coils_b = '0;
                        v_lhit    = 1'b1;
                    end
                    n_ratio_cd = v_ratio;
                end
                if (v_sa != '0 || v_sb != '0) begin
                    v_step = 1'b1;
                    if (v_sa != '0) begin
                        n_coils_a = v_adv_a.coils;
                        n_phase_a = v_adv_a.phase;
                    end
                    // motor b steps on the last count of the ratio
                    if (v_sb != '0 && n_ratio_cd == dsps_pkg::RATIO_W'(1)) begin
                        n_coils_b = v_adv_b.coils;
                        n_phase_b = v_adv_b.phase;
                    end
                    n_ratio_cd = (n_ratio_cd <= dsps_pkg::RATIO_W'(1)) ? v_ratio
                                                                      : n_ratio_cd - 1'b1;
                    v_bnext = {1'b0, r_burst} + 1'b1;
                    n_burst = (v_bnext >= v_slots) ? '0 : v_bnext[dsps_pkg::SLOTS_W-1:0];
                end
            end
            n_speed_a = v_sa;
            n_speed_b = v_sb;
        end

        v_ma = mag(v_sa);
        v_mb = mag(v_sb);

        // pending result, the delay is filled in by the divider
        n_pend               = r_pend;
        n_pend.coils_a       = n_coils_a;
        n_pend.coils_b       = n_coils_b;
        n_pend.slot_delay_ms = '0;
        n_pend.moving        = (v_sa != '0 || v_sb != '0);
        n_pend.timed_out     = v_tout;
        n_pend.limit_hit     = v_lhit;

        // sequencer and one-bit-per-cycle restoring divider
        n_state     = r_state;
        n_div_q     = r_div_q;
        n_div_rem   = r_div_rem;
        n_div_d     = r_div_d;
        n_div_cnt   = r_div_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_div_rem = '0;
                    n_div_cnt = '0;
                    n_div_d   = (v_ma > v_mb) ? v_ma : v_mb;
                    if (v_step) begin
                        n_div_q = r_base_delay;
                        n_state = ST_DIV;
                    end else begin
                        n_div_q = '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                logic [MAG_W:0] v_trial;
                v_trial = {r_div_rem, r_div_q[dsps_pkg::DELAY_W-1]};
                if (v_trial >= {1'b0, r_div_d}) begin
                    n_div_rem = MAG_W'(v_trial - {1'b0, r_div_d});
                    n_div_q   = {r_div_q[dsps_pkg::DELAY_W-2:0], 1'b1};
                end else begin
                    n_div_rem = v_trial[MAG_W-1:0];
                    n_div_q   = {r_div_q[dsps_pkg::DELAY_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == CNT_W'(dsps_pkg::DELAY_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out               = r_pend;
                    n_out.slot_delay_ms = r_div_q;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // pending result is kept until the next beat is taken
        if (!w_in_acc) begin
            n_pend = r_pend;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_mode   <= dsps_pkg::STEP_MODE_RST;
            r_timeout_s   <= dsps_pkg::TIMEOUT_S_RST;
            r_timeout_ms  <= dsps_pkg::ELAPSED_W'(dsps_pkg::MS_PER_SEC);
            r_base_delay  <= dsps_pkg::BASE_DELAY_RST;
            r_speed_ratio <= dsps_pkg::SPEED_RATIO_RST;
            r_slots_burst <= dsps_pkg::SLOTS_BURST_RST;
            r_limit_en    <= 1'b1;
            r_limit_level <= 1'b1;
            r_speed_a     <= '0;
            r_speed_b     <= '0;
            r_phase_a     <= '0;
            r_phase_b     <= '0;
            r_coils_a     <= '0;
            r_coils_b     <= '0;
            r_ratio_cd    <= dsps_pkg::RATIO_W'(1);
            r_burst       <= '0;
            r_elapsed     <= '0;
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            r_step_mode   <= n_step_mode;
            r_timeout_s   <= n_timeout_s;
            r_timeout_ms  <= n_timeout_ms;
            r_base_delay  <= n_base_delay;
            r_speed_ratio <= n_speed_ratio;
            r_slots_burst <= n_slots_burst;
            r_limit_en    <= n_limit_en;
            r_limit_level <= n_limit_level;
            r_speed_a     <= n_speed_a;
            r_speed_b     <= n_speed_b;
            r_phase_a     <= n_phase_a;
            r_phase_b     <= n_phase_b;
            r_coils_a     <= n_coils_a;
            r_coils_b     <= n_coils_b;
            r_ratio_cd    <= n_ratio_cd;
            r_burst       <= n_burst;
            r_elapsed     <= n_elapsed;
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
        r_div_d   <= n_div_d;
        r_div_cnt <= n_div_cnt;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

endmodule
`default_nettype wire

### hdl/dsps_checker.sv
// port-level checker of the dual stepper phase sequencer and its bind
`default_nettype none
module dsps_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire dsps_pkg::t_out_item o_out_data
);

    // a timeout stops everything and reports no delay
    a_timeout_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.timed_out |->
            !o_out_data.moving && o_out_data.coils_a == '0 &&
            o_out_data.coils_b == '0 && o_out_data.slot_delay_ms == '0)
        else $error("timeout beat shows motion");

    // a limit stop clears motor b and cannot coincide with a timeout
    a_limit_clears_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.limit_hit |->
            o_out_data.coils_b == '0 && !o_out_data.timed_out)
        else $error("limit beat leaves motor b energized");

    // a nonzero delay only comes with motion
    a_delay_needs_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.moving |-> o_out_data.slot_delay_ms == '0)
        else $error("delay reported while stopped");

    // one item at a time: an accepted beat blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken back to back");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind dual_stepper_phase_sequencer_core dsps_checker u_dsps_checker (.*);
`default_nettype wire

### test/tb_dual_stepper_phase_sequencer_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the dual stepper phase sequencer core
module tb_dual_stepper_phase_sequencer_core;
    import dsps_pkg::*;

    // command code the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // register index with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // coil patterns, entry p at bits 4p+3..4p
    localparam logic [31:0] HALF_PAT = 32'h98C46231;
    localparam logic [15:0] FULL_PAT = 16'h956A;

    localparam int IN_W          = $bits(t_in_item);
    localparam int SPEED_LIM     = MAX_SPEED_DEF;
    localparam int QUIET_LIMIT   = 4000;   // cycles without any beat or apb access
    localparam int SETTLE_CYCLES = 16;     // lets the divider and sequencer settle
    localparam int MAX_SHOWN     = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    dual_stepper_phase_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // sequencer prediction: registers and motor state as the block keeps them
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]   mode_r;
    logic [TOUT_W-1:0]   tout_r;
    logic [DELAY_W-1:0]  delay_r;
    logic [RATIO_W-1:0]  ratio_r;
    logic [SLOTS_W-1:0]  slots_r;
    logic                lim_en_r;
    logic                lim_lvl_r;

    logic signed [4:0]     spd_a, spd_b;
    logic [PHASE_W-1:0]    ph_a, ph_b;
    logic [COIL_W-1:0]     coil_a, coil_b;
    logic [RATIO_W-1:0]    ratio_cnt;
    logic [SLOTS_W-1:0]    burst_pos;
    logic [ELAPSED_W-1:0]  elapsed;

    // reports owed by the block, oldest first
    t_out_item report_q[$];

    int send_gap_pct;
    int stall_pct;
    int n_beats;
    int n_checked;
    int n_errors;
    int n_timeouts;
    int n_limit_hits;

    function automatic void reset_model();
        mode_r    = STEP_MODE_RST;
        tout_r    = TIMEOUT_S_RST;
        delay_r   = BASE_DELAY_RST;
        ratio_r   = SPEED_RATIO_RST;
        slots_r   = SLOTS_BURST_RST;
        lim_en_r  = 1'b1;
        lim_lvl_r = 1'b1;
        spd_a     = '0;
        spd_b     = '0;
        ph_a      = '0;
        ph_b      = '0;
        coil_a    = '0;
        coil_b    = '0;
        ratio_cnt = RATIO_W'(1);
        burst_pos = '0;
        elapsed   = '0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_STEP_MODE: begin
                // out-of-range step modes are dropped
                if (val[3:0] >= 4'd1 && val[3:0] <= MODE_MAX) mode_r = val[3:0];
            end
            REG_TIMEOUT_S:   tout_r    = val[TOUT_W-1:0];
            REG_BASE_DELAY:  delay_r   = val[DELAY_W-1:0];
            REG_SPEED_RATIO: ratio_r   = val[RATIO_W-1:0];
            REG_SLOTS_BURST: slots_r   = val[SLOTS_W-1:0];
            REG_LIMIT_EN:    lim_en_r  = val[0];
            REG_LIMIT_LEVEL: lim_lvl_r = val[0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [4:0] clamp_speed(input logic signed [SPEED_W-1:0] s);
        int v;
        v = int'(s);
        if (v > SPEED_LIM) v = SPEED_LIM;
        if (v < -SPEED_LIM) v = -SPEED_LIM;
        return 5'(v);
    endfunction

    function automatic int magnitude(input logic signed [4:0] s);
        int v;
        v = int'(s);
        return (v < 0) ? -v : v;
    endfunction

    // output the current phase, then move it; the wrap goes to the far end,
    // not modulo
    function automatic void step_phase(inout logic [PHASE_W-1:0] ph,
                                       input logic signed [4:0] spd,
                                       inout logic [COIL_W-1:0] coils);
        int p;
        p = int'(ph);
        if (mode_r == FULL_STEP_MODE) begin
            if (p < 4) coils = FULL_PAT[4*p +: 4];
            else coils = 4'b0000;
            p = (spd < 0) ? p + 1 : p - 1;
            if (p > 3) p = 0;
            if (p < 0) p = 3;
        end else begin
            coils = HALF_PAT[4*p +: 4];
            p = (spd < 0) ? p + int'(mode_r) : p - int'(mode_r);
            if (p > 7) p = 0;
            if (p < 0) p = 7;
        end
        ph = PHASE_W'(p);
    endfunction

    function automatic t_out_item next_report(input t_in_item it);
        t_out_item          r;
        logic [RATIO_W-1:0] ratio_eff;
        logic [SLOTS_W-1:0] slots_eff;
        int                 big;
        logic               lvl;
        r = '0;
        ratio_eff = (ratio_r == '0) ? RATIO_W'(1) : ratio_r;
        slots_eff = (slots_r == '0) ? SLOTS_W'(1) : slots_r;
        if (it.cmd == CMD_SPEED) begin
            spd_a = clamp_speed(it.speed_a);
            spd_b = clamp_speed(it.speed_b);
            if (spd_a == 0) begin
                coil_a = '0;
                ph_a   = '0;
            end
            if (spd_b == 0) begin
                coil_b = '0;
                ph_b   = '0;
            end
            if (spd_a != 0 || spd_b != 0) elapsed = '0;
            burst_pos = '0;
            ratio_cnt = ratio_eff;
        end else if (it.cmd == CMD_TICK) begin
            if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
        end else if (it.cmd == CMD_SLOT && (spd_a != 0 || spd_b != 0)) begin
            if (burst_pos == '0) begin
                if (tout_r != '0 && 32'(elapsed) >= 32'(tout_r) * 32'(MS_PER_SEC)) begin
                    spd_a  = '0;
                    spd_b  = '0;
                    ph_a   = '0;
                    ph_b   = '0;
                    coil_a = '0;
                    coil_b = '0;
                    r.timed_out = 1'b1;
                    n_timeouts++;
                end
                if (lim_en_r && spd_b != 0) begin
                    // direction picks which end switch matters
                    lvl = (spd_b < 0) ? it.limit_left : it.limit_right;
                    if (lvl == lim_lvl_r) begin
                        spd_b  = '0;
                        ph_b   = '0;
                        coil_b = '0;
                        r.limit_hit = 1'b1;
                        n_limit_hits++;
                    end
                end
                ratio_cnt = ratio_eff;
            end
            if (spd_a != 0 || spd_b != 0) begin
                if (spd_a != 0) step_phase(ph_a, spd_a, coil_a);
                if (spd_b != 0 && ratio_cnt == RATIO_W'(1)) step_phase(ph_b, spd_b, coil_b);
                if (ratio_cnt <= RATIO_W'(1)) ratio_cnt = ratio_eff;
                else ratio_cnt = ratio_cnt - 1'b1;
                big = (magnitude(spd_a) > magnitude(spd_b)) ? magnitude(spd_a)
                                                            : magnitude(spd_b);
                r.slot_delay_ms = DELAY_W'(int'(delay_r) / big);
                burst_pos = burst_pos + 1'b1;
                if (burst_pos >= slots_eff) burst_pos = '0;
            end
        end
        r.coils_a = coil_a;
        r.coils_b = coil_b;
        r.moving  = (spd_a != 0 || spd_b != 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one command beat; random gaps first, valid held until taken
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input int sa, input int sb,
                             input logic ll, input logic lr);
        t_in_item it;
        it.cmd         = cmd;
        it.speed_a     = SPEED_W'(sa);
        it.speed_b     = SPEED_W'(sb);
        it.limit_left  = ll;
        it.limit_right = lr;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            i_in_data  <= IN_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        report_q.push_back(next_report(it));
        n_beats++;
    endtask

    // hold off until every owed report is back and the divider has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] mode, input logic [31:0] tout,
                               input logic [31:0] dly, input logic [31:0] ratio,
                               input logic [31:0] slots, input logic [31:0] en,
                               input logic [31:0] lvl);
        write_reg(REG_STEP_MODE, mode);
        write_reg(REG_TIMEOUT_S, tout);
        write_reg(REG_BASE_DELAY, dly);
        write_reg(REG_SPEED_RATIO, ratio);
        write_reg(REG_SLOTS_BURST, slots);
        write_reg(REG_LIMIT_EN, en);
        write_reg(REG_LIMIT_LEVEL, lvl);
    endtask

    // mostly in and just past the clamp range, some zeros, some anything
    function automatic int rand_speed();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 25) return int'($urandom_range(255)) - 128;
        return int'($urandom_range(24)) - 12;
    endfunction

    function automatic logic rand_switch();
        return ($urandom_range(99) < 25);
    endfunction

    // speed command followed by a run of slots with ticks, unused codes and speed commands mixed in
    task automatic run_motion(input int n_items);
        int               sent;
        int               run_len;
        int               pick;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < n_items) begin
            send_beat(CMD_SPEED, rand_speed(), rand_speed(), rand_switch(), rand_switch());
            sent++;
            run_len = $urandom_range(40, 1);
            for (int k = 0; k < run_len; k++) begin
                pick = $urandom_range(99);
                if (pick < 78) cmd = CMD_SLOT;
                else if (pick < 90) cmd = CMD_TICK;
                else if (pick < 95) cmd = CMD_UNUSED;
                else cmd = CMD_SPEED;
                if (cmd == CMD_SPEED)
                    send_beat(cmd, rand_speed(), rand_speed(), rand_switch(), rand_switch());
                else
                    send_beat(cmd, int'($urandom_range(255)) - 128,
                              int'($urandom_range(255)) - 128, rand_switch(), rand_switch());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: clamping, stops, switch direction, unused code
    task automatic test_directed();
        send_beat(CMD_SLOT, 5, 5, 1'b1, 1'b1);          // slot while stopped
        send_beat(CMD_TICK, 0, 0, 1'b0, 1'b0);
        send_beat(CMD_UNUSED, 127, -128, 1'b1, 1'b1);   // changes nothing
        send_beat(CMD_SPEED, 127, -128, 1'b0, 1'b0);    // both clamp
        repeat (4) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        send_beat(CMD_SPEED, 1, 1, 1'b0, 1'b0);
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b1);          // right switch stops b
        send_beat(CMD_SLOT, 0, 0, 1'b1, 1'b1);
        send_beat(CMD_SPEED, 0, 5, 1'b0, 1'b0);         // a off, coils cleared
        send_beat(CMD_SLOT, 0, 0, 1'b1, 1'b0);          // left switch ignored going right
        send_beat(CMD_SPEED, -11, 11, 1'b0, 1'b0);
        send_beat(CMD_SLOT, 0, 0, 1'b1, 1'b1);
        send_beat(CMD_SPEED, -1, -10, 1'b0, 1'b0);
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b1);
        send_beat(CMD_SLOT, 0, 0, 1'b1, 1'b1);          // mid burst, switches not looked at
        send_beat(CMD_SPEED, 0, 0, 1'b0, 1'b0);         // full stop
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        send_beat(CMD_SPEED, 127, 0, 1'b1, 1'b1);
        repeat (2) send_beat(CMD_SLOT, -1, -1, 1'b1, 1'b1);
        send_beat(CMD_TICK, -128, 127, 1'b1, 1'b1);
    endtask

    // rejected mode writes, unknown index, zero ratio/burst, full step, extremes
    task automatic test_config_extremes();
        wait_idle();
        write_reg(REG_STEP_MODE, 32'd3);
        send_beat(CMD_SPEED, 6, -9, 1'b0, 1'b0);
        repeat (5) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_STEP_MODE, 32'd0);
        write_reg(REG_STEP_MODE, 32'hFFFF_FFF9);
        write_reg(REG_STEP_MODE, 32'd15);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (3) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        wait_idle();
        // full step picks up whatever half-step phase was left
        load_config(FULL_STEP_MODE, 0, 32'hABCD_12FF, 0, 0, 0, 0);
        repeat (6) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        send_beat(CMD_SPEED, -3, 7, 1'b0, 1'b0);
        repeat (4) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        wait_idle();
        load_config(MODE_MAX, 32'd1, 0, 15, 255, 1, 0);
        send_beat(CMD_SPEED, 10, 1, 1'b1, 1'b1);
        repeat (20) send_beat(CMD_SLOT, 0, 0, 1'b1, 1'b1);
        send_beat(CMD_SPEED, 5, -5, 1'b0, 1'b1);        // low left switch is the end now
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b1);
        wait_idle();
        load_config(STEP_MODE_RST, TIMEOUT_S_RST, BASE_DELAY_RST, SPEED_RATIO_RST,
                    SLOTS_BURST_RST, 1, 1);
    endtask

    // elapsed time: disabled timeout, one below the threshold, at the threshold
    task automatic test_timeout();
        wait_idle();
        // every slot opens a burst so every slot checks the timeout
        load_config(2, 0, 40, 2, 1, 0, 1);
        send_beat(CMD_SPEED, 3, -7, 1'b0, 1'b0);
        repeat (999) send_beat(CMD_TICK, 0, 0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_TIMEOUT_S, 32'd1);
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);          // 999 ms, still running
        send_beat(CMD_TICK, 0, 0, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_TIMEOUT_S, 32'd0);
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);          // disabled
        wait_idle();
        write_reg(REG_TIMEOUT_S, 32'd1);
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);          // stops here
        send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
        send_beat(CMD_SPEED, 0, 0, 1'b0, 1'b0);         // zero speeds keep the elapsed time
        send_beat(CMD_SPEED, 4, 0, 1'b0, 1'b0);         // restarts it
        repeat (3) send_beat(CMD_SLOT, 0, 0, 1'b0, 1'b0);
    endtask

    // four traffic mixes, each with its own register setting and a drain midway
    task automatic test_random_traffic();
        for (int mix = 0; mix < 4; mix++) begin
            wait_idle();
            case (mix)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                    load_config(1, 0, 255, 1, 1, 1, 1);
                end
                1: begin
                    send_gap_pct = 63;
                    stall_pct    = 0;
                    load_config(FULL_STEP_MODE, 65535, 0, 15, 255, 0, 0);
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 63;
                    load_config(MODE_MAX, 0, $urandom_range(255), 0, 0, 1, 0);
                end
                default: begin
                    send_gap_pct = 29;
                    stall_pct    = 29;
                    load_config($urandom_range(8, 1), 0, $urandom_range(255),
                                $urandom_range(15, 1), $urandom_range(12, 1), 1,
                                $urandom_range(1));
                end
            endcase
            run_motion(95);
            wait_idle();
            run_motion(95);
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
                $display("report %0d: %s expected %0d got %0d", n_checked, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_reports
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (report_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("report %0d arrived with none owed: %h", n_checked, o_out_data);
            end else begin
                want = report_q.pop_front();
                check_field("coils_a", 8'(want.coils_a), 8'(o_out_data.coils_a));
                check_field("coils_b", 8'(want.coils_b), 8'(o_out_data.coils_b));
                check_field("slot_delay_ms", want.slot_delay_ms, o_out_data.slot_delay_ms);
                check_field("moving", 8'(want.moving), 8'(o_out_data.moving));
                check_field("timed_out", 8'(want.timed_out), 8'(o_out_data.timed_out));
                check_field("limit_hit", 8'(want.limit_hit), 8'(o_out_data.limit_hit));
            end
        end
    end

    // ends a run that stops making progress
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("dual_stepper_phase_sequencer_core verification failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        send_gap_pct = 0;
        stall_pct    = 0;
        n_beats      = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_timeouts   = 0;
        n_limit_hits = 0;
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_timeout();
        test_random_traffic();
        wait_idle();

        $display("sent %0d beats, checked %0d reports, %0d mismatches", n_beats, n_checked,
                 n_errors);
        $display("saw %0d timeout stops and %0d limit stops over half, full and max step modes",
                 n_timeouts, n_limit_hits);
        if (n_errors == 0)
            $display("dual_stepper_phase_sequencer_core verification clean");
        else
            $display("dual_stepper_phase_sequencer_core verification failed");
        $finish;
    end

endmodule

### files.f
hdl/dsps_pkg.sv
hdl/dual_stepper_phase_sequencer_core.sv
hdl/dsps_checker.sv
test/tb_dual_stepper_phase_sequencer_core.sv
